// ===== hw/rtl/sorted_array_priority_queue_top_assert.svh =====
// Assertion macros shared by the priority queue RTL.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SAPQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Invariant checked on every clock edge outside reset.
`define SAPQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error(msg);

`endif

// ===== hw/rtl/sapq_pkg.sv =====
package sapq_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;

	// Operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Result error codes
	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic                     push_en;
		logic                     pop_en;
		logic signed [DATA_W-1:0] value;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/sapq_cell.sv =====
// One slot of the descending chain: slot 0 holds the maximum.
module sapq_cell
	import sapq_pkg::*;
(
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic                     occupied,    // slot index below occupancy
	input  logic                     left_keep,   // lower neighbor keeps its entry
	input  logic signed [DATA_W-1:0] left_entry,  // lower neighbor entry
	input  logic signed [DATA_W-1:0] right_entry, // upper neighbor entry
	output logic                     keep,
	output logic signed [DATA_W-1:0] entry
);

	logic signed [DATA_W-1:0] entry_q;

	// Strictly greater entries stay put, so a new value lands ahead of equals
	assign keep  = occupied && (entry_q > ctrl.value);
	assign entry = entry_q;

	// Push shifts toward the tail, pop shifts toward the head
	always_ff @(posedge clk) begin
		if (ctrl.push_en) begin
			if (!keep) begin
				entry_q <= left_keep ? ctrl.value : left_entry;
			end
		end else if (ctrl.pop_en) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== hw/rtl/sorted_array_priority_queue_top.sv =====
// Sorted max-priority queue of signed 32-bit values.
// Request channel: start with op and value, accepted at a rising edge where
// start is high and busy is low. busy is held low: a request may be issued in
// every cycle. op selects push (insert value) or pop (drop the maximum).
// Result channel: done pulses for one cycle, in the cycle after each accepted
// request, with max_value, is_empty, entry_count and error valid in that cycle.
// Throughput is one request per cycle; the chain of cells
// compares every slot against the broadcast value in parallel and shifts the
// whole row at once. A pop on an empty queue and a push on a full
// queue leave the state unchanged and report an error code.
// Reset clears the occupancy and the result strobe; slot contents are not
// cleared and are read only below the occupancy. The receiver cannot stall:
// each result is shown for exactly one cycle and must be taken then.
`include "sorted_array_priority_queue_top_assert.svh"

module sorted_array_priority_queue_top
	import sapq_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic signed [DATA_W-1:0] max_value,
	output logic                     is_empty,
	output logic [COUNT_W-1:0]       entry_count,
	output logic [1:0]               error
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] occ_q;
	logic             done_q;
	err_t             err_q;

	logic             accept;
	logic             full;
	logic             empty;
	cell_ctrl_t       ctrl;

	logic                     keep    [CAPACITY];
	logic signed [DATA_W-1:0] entries [CAPACITY];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (occ_q == CNT_W'(CAPACITY));
	assign empty  = (occ_q == '0);

	// Broadcast control
	assign ctrl.push_en = accept && (op == OP_PUSH) && !full;
	assign ctrl.pop_en  = accept && (op == OP_POP) && !empty;
	assign ctrl.value   = value;

	// Row of cells, slot 0 is the maximum
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     l_keep;
		logic signed [DATA_W-1:0] l_entry;
		logic signed [DATA_W-1:0] r_entry;

		if (i == 0) begin : g_head
			assign l_keep  = 1'b1;
			assign l_entry = value;
		end else begin : g_body
			assign l_keep  = keep[i-1];
			assign l_entry = entries[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_entry = '0;
		end else begin : g_inner
			assign r_entry = entries[i+1];
		end

		sapq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occ_q > CNT_W'(i)),
			.left_keep   (l_keep),
			.left_entry  (l_entry),
			.right_entry (r_entry),
			.keep        (keep[i]),
			.entry       (entries[i])
		);
	end

	// Occupancy, error code and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			done_q <= 1'b0;
			err_q  <= ERR_OK;
		end else begin
			done_q <= accept;
			if (accept) begin
				case (op)
					OP_PUSH: begin
						if (full) begin
							err_q <= ERR_FULL;
						end else begin
							err_q <= ERR_OK;
							occ_q <= occ_q + CNT_W'(1);
						end
					end
					OP_POP: begin
						if (empty) begin
							err_q <= ERR_EMPTY;
						end else begin
							err_q <= ERR_OK;
							occ_q <= occ_q - CNT_W'(1);
						end
					end
					default: err_q <= ERR_OK;
				endcase
			end
		end
	end

	// Result fields read straight from the state
	assign done        = done_q;
	assign is_empty    = empty;
	assign max_value   = empty ? '0 : entries[0];
	assign entry_count = COUNT_W'(occ_q);
	assign error       = err_q;

	// Checks
	`SAPQ_ASSERT_ALWAYS(a_occ_bound, occ_q <= CNT_W'(CAPACITY), "occupancy above capacity")
	`SAPQ_ASSERT_IMPL(a_full_err, done_q && err_q == ERR_FULL, full, "full error while not full")
	`SAPQ_ASSERT_IMPL(a_empty_err, done_q && err_q == ERR_EMPTY, empty, "empty error while not empty")
	`SAPQ_ASSERT_IMPL(a_push_grow, ctrl.push_en, ##1 occ_q == $past(occ_q) + CNT_W'(1), "push did not grow queue")

endmodule
